// File: design/fbfa_pkg.sv
package fbfa_pkg;

  // field and register widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int ST_W    = 2;
  localparam int OFS_W   = 21;
  localparam int CAP_W   = 9;
  localparam int SIZE_W  = 13;
  localparam int ASZ_W   = SIZE_W + 1;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE_ALL = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_RAW_BYTES = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_ALIGNMENT = 2'd2;

  // configuration reset values
  localparam logic [CAP_W-1:0]  CAPACITY_RST  = 9'd256;
  localparam logic [SIZE_W-1:0] RAW_BYTES_RST = 13'd16;
  localparam logic [SIZE_W-1:0] ALIGNMENT_RST = 13'd8;
  // 16 rounded up to a multiple of 8
  localparam logic [ASZ_W-1:0]  ASIZE_RST     = 14'd16;

  typedef struct packed {
    logic load;
    logic exec;
    logic walk_init;
    logic walk_step;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            walk_done;
    logic            out_free;
  } sts_t;

endpackage

// File: design/fbfa_size.sv
module fbfa_size (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fbfa_pkg::SIZE_W-1:0]    raw_block_bytes,
  input  logic [fbfa_pkg::SIZE_W-1:0]    alignment_bytes,
  output logic                           busy,
  output logic [fbfa_pkg::ASZ_W-1:0]     aligned_size
);

  localparam int SW    = fbfa_pkg::SIZE_W;
  localparam int STEP_W = $clog2(SW + 1);

  logic [SW-1:0]     raw_q;
  logic [SW-1:0]     dvd;
  logic [SW-1:0]     dvs;
  logic [SW-1:0]     rem;
  logic [STEP_W-1:0] steps;
  logic [SW:0]       trial;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem, dvd[SW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      aligned_size <= fbfa_pkg::ASIZE_RST;
    end else if (start) begin
      busy  <= 1'b1;
      raw_q <= raw_block_bytes;
      dvd   <= raw_block_bytes;
      dvs   <= (alignment_bytes == '0) ? SW'(1) : alignment_bytes;
      rem   <= '0;
      steps <= STEP_W'(SW);
    end else if (busy) begin
      if (steps != '0) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= SW'(trial - {1'b0, dvs});
        end else begin
          rem <= SW'(trial);
        end
        dvd   <= {dvd[SW-2:0], 1'b0};
        steps <= steps - STEP_W'(1);
      end else begin
        busy <= 1'b0;
        if (rem == '0) begin
          aligned_size <= fbfa_pkg::ASZ_W'(raw_q);
        end else begin
          aligned_size <= fbfa_pkg::ASZ_W'(raw_q) + fbfa_pkg::ASZ_W'(dvs)
                          - fbfa_pkg::ASZ_W'(rem);
        end
      end
    end
  end

endmodule

// File: design/fbfa_ctrl.sv
module fbfa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           hold,
  input  fbfa_pkg::sts_t sts,
  output logic           in_stall,
  output fbfa_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_DONE} state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE) || hold;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !hold) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op == fbfa_pkg::OP_FREE_ALL) begin
          cmd.walk_init = 1'b1;
          state_next    = S_WALK;
        end else if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_next = S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/fbfa_dpath.sv
module fbfa_dpath #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fbfa_pkg::cmd_t                cmd,
  output fbfa_pkg::sts_t                sts,
  input  logic [fbfa_pkg::OP_W-1:0]     opcode,
  input  logic [fbfa_pkg::IDX_W-1:0]    block_index,
  input  logic [fbfa_pkg::CAP_W-1:0]    capacity,
  input  logic [fbfa_pkg::ASZ_W-1:0]    aligned_size,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [fbfa_pkg::ST_W-1:0]     status,
  output logic [fbfa_pkg::IDX_W-1:0]    alloc_index,
  output logic [fbfa_pkg::OFS_W-1:0]    alloc_offset
);

  localparam int BW     = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W = BW + fbfa_pkg::ASZ_W;

  logic [fbfa_pkg::OP_W-1:0]  item_op;
  logic [fbfa_pkg::IDX_W-1:0] item_idx;
  logic [BW-1:0]              head;
  logic                       head_valid;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           eff_cap;
  logic                       in_range;
  logic [BW:0]                link_mem [MAX_BLOCKS];
  logic [BW:0]                rd_data;
  logic                       mem_we;
  logic [BW-1:0]              mem_addr;
  logic [PROD_W-1:0]          prod;
  logic                       do_alloc;
  logic                       do_free;

  always_comb begin
    if (32'(capacity) > 32'(MAX_BLOCKS)) begin
      eff_cap = CNT_W'(MAX_BLOCKS);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  assign in_range = 32'(item_idx) < 32'(eff_cap);
  assign do_alloc = cmd.exec && (item_op == fbfa_pkg::OP_ALLOC) && head_valid;
  assign do_free  = cmd.exec && (item_op == fbfa_pkg::OP_FREE) && in_range;
  assign mem_we   = do_free || cmd.walk_step;
  assign mem_addr = cmd.walk_step ? cnt[BW-1:0] : BW'(item_idx);
  assign prod     = PROD_W'(head) * PROD_W'(aligned_size);

  assign sts.op        = item_op;
  assign sts.walk_done = (cnt == eff_cap);
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op  <= opcode;
      item_idx <= block_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      head       <= '0;
      cnt        <= '0;
    end else if (cmd.walk_init) begin
      head_valid <= 1'b0;
      cnt        <= '0;
    end else if (cmd.walk_step) begin
      head       <= cnt[BW-1:0];
      head_valid <= 1'b1;
      cnt        <= cnt + CNT_W'(1);
    end else if (do_alloc) begin
      head       <= rd_data[BW-1:0];
      head_valid <= rd_data[BW];
    end else if (do_free) begin
      head       <= BW'(item_idx);
      head_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_addr] <= {head_valid, head};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= link_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= fbfa_pkg::ST_OK;
      alloc_index  <= '0;
      alloc_offset <= '0;
      unique case (item_op)
        fbfa_pkg::OP_ALLOC: begin
          if (head_valid) begin
            alloc_index  <= fbfa_pkg::IDX_W'(head);
            alloc_offset <= fbfa_pkg::OFS_W'(prod);
          end else begin
            status <= fbfa_pkg::ST_EMPTY;
          end
        end
        fbfa_pkg::OP_FREE: begin
          if (!in_range) begin
            status <= fbfa_pkg::ST_RANGE;
          end
        end
        default: begin
          status <= fbfa_pkg::ST_OK;
        end
      endcase
    end
  end

endmodule

// File: design/fixed_block_free_list_allocator.sv
// Fixed-size block pool allocator built around a LIFO free list: one link word per block in an
// on-chip link memory plus a head register. Allocate registers the link read at the head, then
// pops and forms index times aligned size; free all walks min(capacity, MAX_BLOCKS) link
// entries, writing one per cycle. A result sits in an output register, so an input transaction
// can be taken while the last result still waits; a result that is not taken holds the next
// one back. A write to the block size or alignment register starts a bit-serial remainder unit
// that rounds the size up; from such a write until the unit is done the input stays stalled.
// The list is empty after reset until a free or a free-all builds it. A capacity write only
// changes the free range check and the next free-all; blocks already on the list are still
// handed out. A double free is not caught.
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [fbfa_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [fbfa_pkg::CFG_W-1:0]    cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fbfa_pkg::OP_W-1:0]     opcode,
  input  logic [fbfa_pkg::IDX_W-1:0]    block_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fbfa_pkg::ST_W-1:0]     status,
  output logic [fbfa_pkg::IDX_W-1:0]    alloc_index,
  output logic [fbfa_pkg::OFS_W-1:0]    alloc_offset
);

  // configuration registers
  logic [fbfa_pkg::CAP_W-1:0]  capacity;
  logic [fbfa_pkg::SIZE_W-1:0] raw_block_bytes;
  logic [fbfa_pkg::SIZE_W-1:0] alignment_bytes;

  logic                        size_wr;
  logic                        size_start;
  logic                        sz_busy;
  logic [fbfa_pkg::ASZ_W-1:0]  aligned_size;
  logic                        hold;
  fbfa_pkg::cmd_t              cmd;
  fbfa_pkg::sts_t              sts;

  // a size or alignment write kicks off the rounding unit in the next cycle
  assign size_wr = cfg_we && ((cfg_index == fbfa_pkg::CFG_RAW_BYTES) ||
                              (cfg_index == fbfa_pkg::CFG_ALIGNMENT));

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity        <= fbfa_pkg::CAPACITY_RST;
      raw_block_bytes <= fbfa_pkg::RAW_BYTES_RST;
      alignment_bytes <= fbfa_pkg::ALIGNMENT_RST;
      size_start      <= 1'b0;
    end else begin
      size_start <= size_wr;
      if (cfg_we) begin
        unique case (cfg_index)
          fbfa_pkg::CFG_CAPACITY:  capacity        <= cfg_data[fbfa_pkg::CAP_W-1:0];
          fbfa_pkg::CFG_RAW_BYTES: raw_block_bytes <= cfg_data;
          fbfa_pkg::CFG_ALIGNMENT: alignment_bytes <= cfg_data;
          default: ;  // unmapped index, write dropped
        endcase
      end
    end
  end

  // hold off new transactions while the aligned size is stale
  assign hold = sz_busy || size_start || size_wr;

  fbfa_size u_size (
    .clk             (clk),
    .rst             (rst),
    .start           (size_start),
    .raw_block_bytes (raw_block_bytes),
    .alignment_bytes (alignment_bytes),
    .busy            (sz_busy),
    .aligned_size    (aligned_size)
  );

  fbfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .hold     (hold),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  fbfa_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .block_index  (block_index),
    .capacity     (capacity),
    .aligned_size (aligned_size),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .alloc_index  (alloc_index),
    .alloc_offset (alloc_offset)
  );

  // one transaction at a time: an accepted request blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted back to back");

  // no request enters while the aligned size is being recomputed
  a_size_hold: assert property (@(posedge clk) disable iff (rst)
    sz_busy |-> in_stall)
    else $error("request accepted with stale aligned size");

  // only known status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == fbfa_pkg::ST_OK || status == fbfa_pkg::ST_EMPTY ||
                   status == fbfa_pkg::ST_RANGE))
    else $error("bad status code");

  // a failed transaction reports no block
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != fbfa_pkg::ST_OK) |-> (alloc_index == '0 && alloc_offset == '0))
    else $error("failed transaction carries a block");

endmodule
